[rtl/wildcard_pattern_matcher_macros.svh]
// Assertion macros for the wildcard pattern matcher.
`ifndef WILDCARD_PATTERN_MATCHER_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled while reset is held
`define WPM_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication failed");
// next-cycle implication, disabled while reset is held
`define WPM_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle implication failed");
`else
`define WPM_ASSERT_IMPL(label, clk, rst_n, a, c)
`define WPM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/wpm_pkg.sv]
// Package: modes, wildcard codes, case folding and cell control bundle.
package wpm_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // control broadcast to every cell
  typedef struct packed {
    logic       rearm;
    logic       step;
    logic       case_sens;
    logic [7:0] text;
  } cell_ctrl_t;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic case_sens);
    if (!case_sens && b >= UPPER_A && b <= UPPER_Z) begin
      return b | CASE_BIT;
    end
    return b;
  endfunction

endpackage

[rtl/wpm_cell.sv]
// One pattern position: stored byte, active bit and star closure link.
module wpm_cell #(
  parameter int IDX = 0,
  parameter int LW  = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wpm_pkg::cell_ctrl_t ctrl,
  input  logic                wr,
  input  logic [7:0]          wbyte,
  input  logic [LW-1:0]       len_nxt,
  input  logic [LW-1:0]       len_r,
  input  logic                adv_in,
  input  logic                cstar_in,
  output logic                adv_out,
  output logic                cstar_out,
  output logic                end_hit
);

  logic [7:0] p_r;
  logic       active_r;
  logic       active_nxt;
  logic [7:0] p_eff;
  logic       en_eff;
  logic       star_eff;
  logic       hit;
  logic       base;
  logic       c;

  assign p_eff    = wr ? wbyte : p_r;
  assign en_eff   = LW'(IDX) < len_nxt;
  assign star_eff = (p_eff == wpm_pkg::STAR_BYTE);

  assign hit = (p_eff == wpm_pkg::ANY_BYTE) ||
               (wpm_pkg::fold(p_eff, ctrl.case_sens) == wpm_pkg::fold(ctrl.text, ctrl.case_sens));

  // text step: move on past a literal/any, or stay on a star
  assign adv_out = ctrl.step & active_r & en_eff & ~star_eff & hit;

  always_comb begin
    if (ctrl.rearm) begin
      base = (IDX == 0);
    end else begin
      base = adv_in | (active_r & en_eff & star_eff);
    end
    c          = base | cstar_in;
    cstar_out  = c & en_eff & star_eff;
    active_nxt = (ctrl.rearm | ctrl.step) ? c : active_r;
  end

  assign end_hit = active_r & (len_r == LW'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= (IDX == 0);
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      p_r <= wbyte;
    end
  end

endmodule

[rtl/wildcard_pattern_matcher.sv]
// Top level: glob matcher built as a row of pattern-position cells.
//
// Usage
//   Input channel (in_valid/in_stall) carries in_mode and in_byte_value:
//     clear pattern, append a pattern byte, give a text byte, end of text.
//     Zero bytes in append and text items are ignored.
//   Result channel (out_valid/out_stall) carries out_matched and
//   out_pattern_overflow, one item per end-of-text item only.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes case_sensitive;
//   cfg_ready is always high. Write it only while the block is idle.
// Timing
//   One item per cycle while in_stall is low. Every cell updates its active bit in the
//   same cycle; star closure ripples down the row of PATTERN_LEN cells.
//   An end-of-text result is registered, in the skid entry while a result waits.
// Stall
//   A result register plus one skid entry: the block keeps taking items
//   while a result waits. in_stall rises only when the skid entry is full.
// Reset
//   rst_n is synchronous, active low: empty pattern, no overflow,
//   case_sensitive = 1, only position zero active, no result pending.
//   Pattern bytes are not cleared; only bytes below the length are used.
module wildcard_pattern_matcher #(
  parameter int PATTERN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_pattern_overflow,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  localparam int LW = $clog2(PATTERN_LEN + 1);

  // control state
  logic [LW-1:0] len_r, len_nxt;
  logic          ovf_r, ovf_nxt;
  logic          case_sens_r;
  logic          last_r, last_nxt;     // active bit of the position after the last cell
  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  // result payload
  logic          out_matched_r, out_matched_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          skid_matched_r, skid_ovf_r;

  logic                accept;
  logic                nonzero;
  logic                is_append;
  logic                full;
  logic                res_new;
  logic                res_matched;
  logic                out_fire;
  wpm_pkg::mode_t      mode;
  wpm_pkg::cell_ctrl_t ctrl;

  logic [PATTERN_LEN:0]   adv;
  logic [PATTERN_LEN:0]   cstar;
  logic [PATTERN_LEN-1:0] end_hit;
  logic                   end_active;

  assign mode      = wpm_pkg::mode_t'(in_mode);
  assign accept    = in_valid & ~in_stall;
  assign nonzero   = (in_byte_value != 8'd0);
  assign full      = (len_r == LW'(PATTERN_LEN));
  assign is_append = accept && (mode == wpm_pkg::MODE_APPEND) && nonzero;
  assign res_new   = accept && (mode == wpm_pkg::MODE_END);

  assign ctrl.rearm = accept && ((mode == wpm_pkg::MODE_CLEAR) || (mode == wpm_pkg::MODE_END) ||
                                 ((mode == wpm_pkg::MODE_APPEND) && nonzero));
  assign ctrl.step      = accept && (mode == wpm_pkg::MODE_TEXT) && nonzero;
  assign ctrl.case_sens = case_sens_r;
  assign ctrl.text      = in_byte_value;

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    if (accept && (mode == wpm_pkg::MODE_CLEAR)) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (is_append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LW'(1);
      end
    end
  end

  // row of cells; adv and cstar chain from cell i into cell i+1
  assign adv[0]   = 1'b0;
  assign cstar[0] = 1'b0;

  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    wpm_cell #(
      .IDX (i),
      .LW  (LW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .wr        (is_append && !full && (len_r == LW'(i))),
      .wbyte     (in_byte_value),
      .len_nxt   (len_nxt),
      .len_r     (len_r),
      .adv_in    (adv[i]),
      .cstar_in  (cstar[i]),
      .adv_out   (adv[i+1]),
      .cstar_out (cstar[i+1]),
      .end_hit   (end_hit[i])
    );
  end

  // final position: reached by a step or by a trailing star run
  always_comb begin
    last_nxt = last_r;
    if (ctrl.rearm) begin
      last_nxt = cstar[PATTERN_LEN];
    end else if (ctrl.step) begin
      last_nxt = adv[PATTERN_LEN] | cstar[PATTERN_LEN];
    end
  end

  assign end_active  = (|end_hit) | (last_r & full);
  assign res_matched = end_active & ~ovf_r;

  // result register with one skid entry
  assign out_fire = out_valid_r & ~out_stall;
  assign in_stall = skid_valid_r;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    skid_valid_nxt  = skid_valid_r;
    out_matched_nxt = out_matched_r;
    out_ovf_nxt     = out_ovf_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_matched_nxt = skid_matched_r;
        out_ovf_nxt     = skid_ovf_r;
        skid_valid_nxt  = 1'b0;
      end else begin
        out_valid_nxt   = res_new;
        out_matched_nxt = res_matched;
        out_ovf_nxt     = ovf_r;
      end
    end else if (res_new) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      ovf_r        <= 1'b0;
      case_sens_r  <= 1'b1;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case_sens_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
    out_ovf_r     <= out_ovf_nxt;
    if (res_new && out_valid_r && !out_fire) begin
      skid_matched_r <= res_matched;
      skid_ovf_r     <= ovf_r;
    end
  end

  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

`include "wildcard_pattern_matcher_macros.svh"

  // a waiting skid item always sits behind a held result
  `WPM_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // an overflowed pattern never reports a match
  `WPM_ASSERT_IMPL(a_ovf_no_match, clk, rst_n, out_valid_r && out_ovf_r, !out_matched_r)
  // a clear empties the pattern and drops the overflow flag
  `WPM_ASSERT_NEXT(a_clear_empties, clk, rst_n, accept && (mode == wpm_pkg::MODE_CLEAR),
                   (len_r == '0) && !ovf_r)
  // length never passes the store capacity
  `WPM_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, len_r <= LW'(PATTERN_LEN))

endmodule

[sim/tb_top.sv]
// Testbench for the wildcard pattern matcher: directed and random glob items, predictor check.
`timescale 1ns / 1ps

module tb_top;

  localparam int PAT_CAP     = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 4;       // the result is registered after acceptance

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports; the inputs are all known from time zero
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode       = wpm_pkg::MODE_CLEAR;
  logic [7:0] in_byte_value = 8'h00;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic       out_matched;
  logic       out_pattern_overflow;
  logic       cfg_valid     = 1'b0;
  logic       cfg_ready;
  logic       cfg_data      = 1'b0;

  wildcard_pattern_matcher #(.PATTERN_LEN(PAT_CAP)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_byte_value        (in_byte_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched          (out_matched),
    .out_pattern_overflow (out_pattern_overflow),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Glob predictor: own copy of pattern store, length, live positions, overflow
  // and the case setting. Live positions are kept closed over stars.
  // ---------------------------------------------------------------------------
  logic [7:0]     pat_store [PAT_CAP];
  int             pat_len;
  logic [PAT_CAP:0] live;
  logic           pat_ovf;
  logic           case_exact;

  verdict_t verdict_q[$];     // verdicts awaiting an end-of-text result
  int       mismatches;
  int       items_sent;       // items that do something (ignored ones excluded)
  bit       no_idle;          // both sides run flat out while set
  int       cycles;

  function automatic logic [7:0] fold_letter(logic [7:0] b);
    if (!case_exact && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  // a live star also makes the position after it live; ripples left to right
  function automatic logic [PAT_CAP:0] close_stars(logic [PAT_CAP:0] v);
    for (int i = 0; i < pat_len; i++)
      if (v[i] && pat_store[i] == wpm_pkg::STAR_BYTE) v[i+1] = 1'b1;
    return v;
  endfunction

  function automatic void rearm_text();
    live    = '0;
    live[0] = 1'b1;
    live    = close_stars(live);
  endfunction

  function automatic void feed_text(logic [7:0] c);
    logic [PAT_CAP:0] nxt;
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live[i]) begin
        if (pat_store[i] == wpm_pkg::STAR_BYTE)
          nxt[i] = 1'b1;
        else if (pat_store[i] == wpm_pkg::ANY_BYTE ||
                 fold_letter(pat_store[i]) == fold_letter(c))
          nxt[i+1] = 1'b1;
      end
    end
    live = close_stars(nxt);
  endfunction

  function automatic void predict_item(wpm_pkg::mode_t m, logic [7:0] b);
    verdict_t v;
    case (m)
      wpm_pkg::MODE_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        rearm_text();
      end
      wpm_pkg::MODE_APPEND: begin
        if (b != 8'h00) begin
          if (pat_len < PAT_CAP) begin
            pat_store[pat_len] = b;
            pat_len++;
          end else begin
            pat_ovf = 1'b1;
          end
          // a new pattern byte forgets any text already given
          rearm_text();
        end
      end
      wpm_pkg::MODE_TEXT: begin
        if (b != 8'h00) feed_text(b);
      end
      default: begin
        v.matched  = live[pat_len] && !pat_ovf;
        v.overflow = pat_ovf;
        verdict_q.push_back(v);
        rearm_text();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_wait();
    return no_idle ? 0 : $urandom_range(0, 6);
  endfunction

  // Sends one item. Valid is left high after acceptance so that a zero gap
  // keeps it high; in this task it is only lowered when a gap is drawn.
  task automatic send_item(wpm_pkg::mode_t m, logic [7:0] b);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_byte_value <= b;
    do @(posedge clk); while (in_stall);
    predict_item(m, b);
    if (m == wpm_pkg::MODE_CLEAR || m == wpm_pkg::MODE_END || b != 8'h00) items_sent++;
  endtask

  // Sender holds off until every verdict is back, then waits out SETTLE.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_case_exact(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    case_exact  = v;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per result, check against the oldest verdict
  // ---------------------------------------------------------------------------
  int stall_hold;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_hold  = 0;
    end else begin
      if (out_valid && !out_stall)
        stall_hold = pick_wait();
      else if (out_valid && stall_hold > 0)
        stall_hold--;
      out_stall <= (stall_hold != 0);
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: matched=%0b overflow=%0b",
                   $realtime, out_matched, out_pattern_overflow);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_matched !== want.matched || out_pattern_overflow !== want.overflow) begin
          if (mismatches < 10)
            $display("[%0t] mismatch: matched exp %0b got %0b, overflow exp %0b got %0b",
                     $realtime, want.matched, out_matched, want.overflow,
                     out_pattern_overflow);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generators
  // ---------------------------------------------------------------------------
  // mostly a small alphabet so that texts hit pattern bytes often
  function automatic logic [7:0] pick_pat_byte();
    case ($urandom_range(0, 9))
      0, 1:    return wpm_pkg::STAR_BYTE;
      2:       return wpm_pkg::ANY_BYTE;
      3:       return 8'($urandom_range(1, 255));
      4:       return 8'h61;
      5:       return 8'h62;
      6:       return 8'h41;
      7:       return 8'h42;
      default: return 8'h63;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1:       return wpm_pkg::STAR_BYTE;
      2:       return 8'h61;
      3:       return 8'h62;
      4:       return 8'h41;
      5:       return 8'h42;
      6:       return 8'h43;
      default: return 8'h63;
    endcase
  endfunction

  // Text built to fit the current pattern, with the odd case swap and the odd
  // wrong byte so that both verdicts turn up.
  task automatic send_fitting_text();
    logic [7:0] snap [PAT_CAP];
    int         n;
    logic [7:0] p;
    n = pat_len;
    for (int i = 0; i < n; i++) snap[i] = pat_store[i];
    for (int i = 0; i < n; i++) begin
      p = snap[i];
      if (p == wpm_pkg::STAR_BYTE) begin
        repeat ($urandom_range(0, 3)) send_item(wpm_pkg::MODE_TEXT, pick_text_byte());
      end else if (p == wpm_pkg::ANY_BYTE) begin
        send_item(wpm_pkg::MODE_TEXT, 8'($urandom_range(1, 255)));
      end else if ($urandom_range(0, 11) == 0) begin
        send_item(wpm_pkg::MODE_TEXT, pick_text_byte());
      end else if (((p | 8'h20) >= 8'h61) && ((p | 8'h20) <= 8'h7A) && $urandom_range(0, 1)) begin
        send_item(wpm_pkg::MODE_TEXT, p ^ 8'h20);
      end else begin
        send_item(wpm_pkg::MODE_TEXT, p);
      end
    end
    if ($urandom_range(0, 9) == 0) send_item(wpm_pkg::MODE_TEXT, pick_text_byte());
    send_item(wpm_pkg::MODE_END, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // edges of the fields, every mode, zero bytes, stale text, empty text
  task automatic test_directed();
    send_item(wpm_pkg::MODE_END, 8'hFF);      // empty pattern, empty text: match
    send_item(wpm_pkg::MODE_APPEND, 8'h00);   // ignored
    send_item(wpm_pkg::MODE_APPEND, 8'hFF);
    send_item(wpm_pkg::MODE_APPEND, 8'h41);
    send_item(wpm_pkg::MODE_TEXT, 8'h00);     // ignored
    send_item(wpm_pkg::MODE_TEXT, 8'hFF);
    send_item(wpm_pkg::MODE_TEXT, 8'h61);     // exact case: 'a' is not 'A'
    send_item(wpm_pkg::MODE_END, 8'h00);
    send_item(wpm_pkg::MODE_TEXT, 8'hFF);
    send_item(wpm_pkg::MODE_TEXT, 8'h41);
    send_item(wpm_pkg::MODE_END, 8'h55);
    send_item(wpm_pkg::MODE_CLEAR, 8'hFF);
    send_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
    send_item(wpm_pkg::MODE_END, 8'h00);      // stars only, empty text: match
    send_item(wpm_pkg::MODE_APPEND, wpm_pkg::ANY_BYTE);
    send_item(wpm_pkg::MODE_TEXT, 8'h80);
    send_item(wpm_pkg::MODE_END, 8'h00);
    send_item(wpm_pkg::MODE_TEXT, 8'h01);
    send_item(wpm_pkg::MODE_APPEND, 8'h7F);   // text so far forgotten
    send_item(wpm_pkg::MODE_TEXT, 8'h01);
    send_item(wpm_pkg::MODE_TEXT, 8'h7F);
    send_item(wpm_pkg::MODE_END, 8'h00);
    send_item(wpm_pkg::MODE_END, 8'h00);      // empty text against '*?' plus a byte fails
  endtask

  // folding only touches A..Z; neighbours of the range stay as they are
  task automatic test_case_folding();
    wait_idle();
    write_case_exact(1'b0);
    send_item(wpm_pkg::MODE_CLEAR, 8'h00);
    send_item(wpm_pkg::MODE_APPEND, 8'h41);
    send_item(wpm_pkg::MODE_APPEND, 8'h7A);
    send_item(wpm_pkg::MODE_APPEND, 8'h5B);
    send_item(wpm_pkg::MODE_APPEND, 8'h40);
    send_item(wpm_pkg::MODE_TEXT, 8'h61);
    send_item(wpm_pkg::MODE_TEXT, 8'h5A);
    send_item(wpm_pkg::MODE_TEXT, 8'h7B);     // '{' against '['
    send_item(wpm_pkg::MODE_TEXT, 8'h40);
    send_item(wpm_pkg::MODE_END, 8'h00);
    send_item(wpm_pkg::MODE_TEXT, 8'h61);
    send_item(wpm_pkg::MODE_TEXT, 8'h5A);
    send_item(wpm_pkg::MODE_TEXT, 8'h5B);
    send_item(wpm_pkg::MODE_TEXT, 8'h60);     // '`' against '@'
    send_item(wpm_pkg::MODE_END, 8'h00);
  endtask

  // full store, then one byte past it, then clear
  task automatic test_overflow();
    wait_idle();
    write_case_exact(1'b1);
    send_item(wpm_pkg::MODE_CLEAR, 8'h00);
    repeat (PAT_CAP - 1) send_item(wpm_pkg::MODE_APPEND, 8'h61);
    send_item(wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE);
    repeat (PAT_CAP - 1) send_item(wpm_pkg::MODE_TEXT, 8'h61);
    send_item(wpm_pkg::MODE_TEXT, 8'h62);
    send_item(wpm_pkg::MODE_END, 8'h00);      // full pattern matches
    send_item(wpm_pkg::MODE_APPEND, 8'h63);   // dropped, overflow set
    repeat (PAT_CAP - 1) send_item(wpm_pkg::MODE_TEXT, 8'h61);
    send_item(wpm_pkg::MODE_END, 8'h00);
    send_item(wpm_pkg::MODE_END, 8'h00);      // overflow kept across end of text
    send_item(wpm_pkg::MODE_CLEAR, 8'h00);
    send_item(wpm_pkg::MODE_END, 8'h00);
  endtask

  // Mostly well-formed pattern/text sequences, some noise, four case phases.
  task automatic test_random(int target);
    int per_phase;
    int stop_at;
    int n;
    per_phase = target / 4;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      write_case_exact(phase[0]);
      stop_at = items_sent + per_phase;
      while (items_sent < stop_at) begin
        no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // noise
          repeat ($urandom_range(1, 4))
            send_item(wpm_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          if ($urandom_range(0, 1)) begin
            send_item(wpm_pkg::MODE_CLEAR, 8'($urandom));
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
            repeat (n) send_item(wpm_pkg::MODE_APPEND, pick_pat_byte());
          end
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 9) == 0) begin
              send_item(wpm_pkg::MODE_TEXT, pick_text_byte());
              send_item(wpm_pkg::MODE_APPEND, pick_pat_byte());
            end
            if ($urandom_range(0, 5) == 0) begin
              repeat ($urandom_range(0, 5)) send_item(wpm_pkg::MODE_TEXT, pick_text_byte());
              send_item(wpm_pkg::MODE_END, 8'($urandom));
            end else begin
              send_fitting_text();
            end
          end
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    pat_len    = 0;
    pat_ovf    = 1'b0;
    case_exact = 1'b1;
    mismatches = 0;
    items_sent = 0;
    no_idle    = 1'b0;
    cycles     = 0;
    for (int i = 0; i < PAT_CAP; i++) pat_store[i] = 8'h00;
    rearm_text();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_case_folding();
    test_overflow();
    test_random(1250);

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[wildcard_pattern_matcher.f]
+incdir+rtl
rtl/wpm_pkg.sv
rtl/wpm_cell.sv
rtl/wildcard_pattern_matcher.sv
sim/tb_top.sv
